// File: design/slcd_pkg.sv
// Shared types and constants for the sync/length/checksum deframer.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package slcd_pkg;

  localparam int unsigned PAYLOAD_MAX_DEF = 32;
  localparam int unsigned HEAD_DEPTH      = 4;

  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;
  localparam logic [7:0] CMD_STATUS  = 8'h52;
  localparam logic [7:0] SUB_STATUS  = 8'h01;

  localparam logic [1:0] EV_ACCEPT   = 2'd0;
  localparam logic [1:0] EV_BADSUM   = 2'd1;
  localparam logic [1:0] EV_OVERFLOW = 2'd2;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_SYNC2 = 2'd1,
    PH_LEN   = 2'd2,
    PH_BODY  = 2'd3
  } slcd_phase_t;

  typedef struct packed {
    logic [1:0] frame_event;
    logic [7:0] command_byte;
    logic [7:0] sub_command_byte;
    logic       status_updated;
    logic [7:0] system_status_out;
    logic [7:0] media_source_out;
  } slcd_result_t;

endpackage

// File: design/slcd_in_stage.sv
// Input register for received bytes; holds a byte until the parser takes it.
// Depends on slcd_pkg (imported for house consistency, no types used here).
`timescale 1ns / 1ps

module slcd_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_data
);
  import slcd_pkg::*;

  logic       held;
  logic [7:0] data;

  // a held byte that the parser cannot take blocks the next transfer
  assign in_stall   = held && !advance;
  assign byte_valid = held;
  assign byte_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!in_stall) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data <= rx_byte;
    end
  end

endmodule

// File: design/slcd_parser.sv
// Frame parser: phase state machine, running sum, captured head bytes and
// latched status. Depends on slcd_pkg for phase, event codes and result struct.
`timescale 1ns / 1ps

module slcd_parser #(
  parameter int unsigned PayloadMax = slcd_pkg::PAYLOAD_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           byte_data,
  output logic                 frame_end,
  output logic                 res_valid,
  output slcd_pkg::slcd_result_t res
);
  import slcd_pkg::*;

  localparam logic [7:0] PayloadLimit = 8'(PayloadMax);

  slcd_phase_t phase, phase_next;
  logic [7:0]  payload_index, payload_index_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [7:0]  captured_head [HEAD_DEPTH];
  logic [7:0]  captured_head_next [HEAD_DEPTH];
  logic [7:0]  system_status, system_status_next;
  logic [7:0]  media_source, media_source_next;

  logic last_byte;
  logic sum_ok;
  logic status_match;

  assign last_byte    = (payload_index == frame_length - 8'd1);
  assign sum_ok       = (running_sum == byte_data);
  assign status_match = (captured_head[0] == CMD_STATUS) && (captured_head[1] == SUB_STATUS);

  // next byte taken in the body ends the frame (checksum or overflow abort)
  assign frame_end = (phase == PH_BODY) && (last_byte || (payload_index >= PayloadLimit));

  always_comb begin
    phase_next         = phase;
    payload_index_next = payload_index;
    running_sum_next   = running_sum;
    frame_length_next  = frame_length;
    captured_head_next = captured_head;
    system_status_next = system_status;
    media_source_next  = media_source;
    res_valid          = 1'b0;
    res.frame_event       = EV_ACCEPT;
    res.command_byte      = captured_head[0];
    res.sub_command_byte  = captured_head[1];
    res.status_updated    = 1'b0;
    res.system_status_out = system_status;
    res.media_source_out  = media_source;

    if (step) begin
      case (phase)
        PH_HUNT: begin
          payload_index_next = 8'd0;
          running_sum_next   = 8'd0;
          frame_length_next  = 8'd0;
          phase_next = (byte_data == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
        end
        PH_SYNC2: begin
          phase_next = (byte_data == SYNC_SECOND) ? PH_LEN : PH_HUNT;
        end
        PH_LEN: begin
          if (byte_data != 8'd0) begin
            frame_length_next = byte_data;
            phase_next        = PH_BODY;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_BODY: begin
          if (last_byte) begin
            // checksum byte
            phase_next = PH_HUNT;
            res_valid  = 1'b1;
            if (sum_ok) begin
              if (status_match) begin
                system_status_next    = captured_head[2];
                media_source_next     = captured_head[3];
                res.status_updated    = 1'b1;
                res.system_status_out = captured_head[2];
                res.media_source_out  = captured_head[3];
              end
              for (int i = 0; i < HEAD_DEPTH; i++) begin
                captured_head_next[i] = 8'd0;
              end
            end else begin
              res.frame_event = EV_BADSUM;
            end
          end else if (payload_index >= PayloadLimit) begin
            phase_next      = PH_HUNT;
            res_valid       = 1'b1;
            res.frame_event = EV_OVERFLOW;
          end else begin
            running_sum_next = running_sum + byte_data;
            if (payload_index < 8'(HEAD_DEPTH)) begin
              captured_head_next[payload_index[1:0]] = byte_data;
            end
            payload_index_next = payload_index + 8'd1;
          end
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      payload_index <= 8'd0;
      running_sum   <= 8'd0;
      frame_length  <= 8'd0;
      system_status <= 8'd0;
      media_source  <= 8'd0;
      for (int i = 0; i < HEAD_DEPTH; i++) begin
        captured_head[i] <= 8'd0;
      end
    end else begin
      phase         <= phase_next;
      payload_index <= payload_index_next;
      running_sum   <= running_sum_next;
      frame_length  <= frame_length_next;
      system_status <= system_status_next;
      media_source  <= media_source_next;
      captured_head <= captured_head_next;
    end
  end

`ifndef ASSERT_OFF
  a_result_from_body: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (step && phase == PH_BODY))
    else $error("result outside frame body");

  a_hunt_after_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> (phase == PH_HUNT))
    else $error("parser not hunting after a finished frame");

  a_index_bounded: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BODY) |-> (payload_index <= PayloadLimit))
    else $error("payload index past limit");

  a_update_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status_updated) |-> (res.frame_event == EV_ACCEPT))
    else $error("status update on a rejected frame");

  a_status_stable_no_step: assert property (@(posedge clk) disable iff (rst)
    !step |=> ($stable(system_status) && $stable(media_source) && $stable(phase)))
    else $error("state changed without a byte");
`endif

endmodule

// File: design/slcd_out_stage.sv
// Result register: holds one finished-frame report until it is taken.
// Depends on slcd_pkg for the result struct.
`timescale 1ns / 1ps

module slcd_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  slcd_pkg::slcd_result_t res,
  output logic                  hold,
  output logic                  out_valid,
  input  logic                  out_stall,
  output slcd_pkg::slcd_result_t out_res
);
  import slcd_pkg::*;

  slcd_result_t data;

  assign hold    = out_valid && out_stall;
  assign out_res = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

endmodule

// File: design/sync_length_checksum_deframer.sv
// Top level of the sync/length/checksum deframer.
// Depends on slcd_pkg, slcd_in_stage, slcd_parser and slcd_out_stage.
`timescale 1ns / 1ps

// Takes one received byte per transfer and reports each finished frame
// (sync 0x55 0xAA, nonzero length L, L-1 payload bytes, mod-256 sum byte):
// event 0 accepted, 1 checksum mismatch, 2 payload overflow abort. A byte
// is taken every cycle unless the input side stalls; the parser loads its
// report into the result register when it takes the frame-ending byte. The
// input side stalls only while a held byte would finish a frame and the
// result register is waiting to be taken. Accepted frames whose payload
// starts 0x52 0x01 latch bytes 2 and 3 as system status and media source.
module sync_length_checksum_deframer #(
  parameter int unsigned PayloadMax = slcd_pkg::PAYLOAD_MAX_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] frame_event,
  output logic [7:0] command_byte,
  output logic [7:0] sub_command_byte,
  output logic       status_updated,
  output logic [7:0] system_status_out,
  output logic [7:0] media_source_out
);
  import slcd_pkg::*;

  logic         byte_valid;
  logic [7:0]   byte_data;
  logic         hold;
  logic         frame_end;
  logic         blocked;
  logic         step;
  logic         res_valid;
  slcd_result_t res;
  slcd_result_t out_res;

  // only a frame-ending byte has to wait for the result register
  assign blocked = hold && frame_end;
  assign step    = byte_valid && !blocked;

  slcd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .advance    (!blocked),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  slcd_parser #(
    .PayloadMax (PayloadMax)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .byte_data (byte_data),
    .frame_end (frame_end),
    .res_valid (res_valid),
    .res       (res)
  );

  slcd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res       (res),
    .hold      (hold),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign frame_event       = out_res.frame_event;
  assign command_byte      = out_res.command_byte;
  assign sub_command_byte  = out_res.sub_command_byte;
  assign status_updated    = out_res.status_updated;
  assign system_status_out = out_res.system_status_out;
  assign media_source_out  = out_res.media_source_out;

endmodule
